/* rtl/pressure_temperature_compensation_unit_macros.svh */
// Assertion helpers for the compensation unit
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_MACROS_SVH

`define PTC_ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define PTC_ASSERT_RESET(lbl, clk, rst_n, sig) \
  lbl: assert property (@(posedge clk) !rst_n |-> !(sig)) \
    else $error("signal active in reset");

`endif

/* rtl/ptc_pkg.sv */
`default_nettype none
package ptc_pkg;
  localparam int unsigned RawW   = 20;
  localparam int unsigned TrimW  = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LongW  = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivSteps = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegT1   = 3'd0,
    RegT2   = 3'd1,
    RegT3   = 3'd2,
    RegP1   = 3'd3,
    RegP2P3 = 3'd4,
    RegP4P5 = 3'd5,
    RegP6P7 = 3'd6,
    RegP8P9 = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [TrimW-1:0]        t1;
    logic signed [TrimW-1:0] t2;
    logic signed [TrimW-1:0] t3;
    logic [TrimW-1:0]        p1;
    logic signed [TrimW-1:0] p2;
    logic signed [TrimW-1:0] p3;
    logic signed [TrimW-1:0] p4;
    logic signed [TrimW-1:0] p5;
    logic signed [TrimW-1:0] p6;
    logic signed [TrimW-1:0] p7;
    logic signed [TrimW-1:0] p8;
    logic signed [TrimW-1:0] p9;
  } trim_t;

  // division job handed between the front and the divider
  typedef struct packed {
    logic [LongW-1:0] num;
    logic [LongW-1:0] den;
    logic [WordW-1:0] temp;
    logic [WordW-1:0] fine;
    logic             zero;
  } div_job_t;

  typedef struct packed {
    logic [LongW-1:0] quo;
    logic [WordW-1:0] temp;
    logic [WordW-1:0] fine;
    logic             zero;
  } div_res_t;
endpackage
`default_nettype wire

/* rtl/ptc_stream_if.sv */
`default_nettype none
interface ptc_stream_if #(
  parameter int unsigned DataW = 40
);
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/ptc_front.sv */
`default_nettype none
// temperature path and the pressure divisor/dividend, 7 stages
module ptc_front
  import ptc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [RawW-1:0]  adc_t_i,
  input  wire logic [RawW-1:0]  adc_p_i,
  input  wire trim_t            trim_i,
  output logic                  valid_o,
  output div_job_t              job_o
);
  logic [3:0] vld_q;

  // stage 1: temperature products
  logic [WordW-1:0] a_q, dd_q;
  logic [RawW-1:0]  p1s_q;
  // stage 2 (fine_q is stage 3)
  logic [WordW-1:0] fine_q, tv1_q, d2_q;
  logic [RawW-1:0]  p2s_q;
  // stage 4
  logic [WordW-1:0] fine3_q, temp3_q;
  logic [LongW-1:0] v1_q, v1sq_q;
  logic [RawW-1:0]  p3s_q;
  // stage 5 products
  logic [LongW-1:0] x6_q, x5_q, x3_q, x2_q;
  logic [WordW-1:0] fine4_q, temp4_q;
  logic [RawW-1:0]  p4s_q;
  // stage 6
  logic [LongW-1:0] v2_q, pv1_q;
  logic [WordW-1:0] fine5_q, temp5_q;
  logic [RawW-1:0]  p5s_q;
  // stage 7
  logic [LongW-1:0] den_q, num_q;
  logic [WordW-1:0] fine6_q, temp6_q;
  logic [RawW-1:0]  p6s_q;
  logic [2:0] vld2_q;

  logic [WordW-1:0] a_d, d_d, tv2_d, fine_d, temp_d;
  logic [LongW-1:0] v1_d, e_d, d47_d, num_d, den_d;
  // v1 fits 33 signed bits, so its square is a 33x33 product
  logic signed [32:0] v1n_d;
  logic signed [65:0] v1sq_d;

  always_comb begin
    a_d   = (WordW'(adc_t_i >> 3) - (WordW'(trim_i.t1) << 1)) *
            WordW'(signed'(trim_i.t2));
    d_d   = WordW'(adc_t_i >> 4) - WordW'(trim_i.t1);
    tv2_d = WordW'($signed(d2_q) >>> 14);
    fine_d = tv1_q + tv2_d;
    temp_d = WordW'($signed(fine_q * 32'd5 + 32'd128) >>> 8);
    v1_d  = LongW'(signed'(fine_q)) - 64'd128000;
    v1n_d = signed'(v1_d[32:0]);
    v1sq_d = v1n_d * v1n_d;
    e_d   = LongW'($signed(x3_q) >>> 8) + (x2_q << 12);
    d47_d = (64'd1 << 47) + pv1_q;
    den_d = LongW'($signed(d47_d * LongW'(trim_i.p1)) >>> 33);
    num_d = (((64'd1048576 - LongW'(p6s_q)) << 31) - v2_q) * 64'd3125;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vld2_q <= '0;
    end else if (en_i) begin
      vld_q  <= {vld_q[2:0], valid_i};
      vld2_q <= {vld2_q[1:0], vld_q[3]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      dd_q  <= d_d * d_d;
      p1s_q <= adc_p_i;
      tv1_q <= WordW'($signed(a_q) >>> 11);
      d2_q  <= WordW'($signed(dd_q) >>> 12) * WordW'(signed'(trim_i.t3));
      p2s_q <= p1s_q;
      fine_q <= fine_d;
      p3s_q <= p2s_q;
      // registered fine path
      fine3_q <= fine_q;
      temp3_q <= temp_d;
      v1_q    <= v1_d;
      v1sq_q  <= v1sq_d[LongW-1:0];
      p4s_q   <= p3s_q;
      x6_q    <= v1sq_q * LongW'(trim_i.p6);
      x5_q    <= (v1_q * LongW'(trim_i.p5)) << 17;
      x3_q    <= v1sq_q * LongW'(trim_i.p3);
      x2_q    <= v1_q * LongW'(trim_i.p2);
      fine4_q <= fine3_q;
      temp4_q <= temp3_q;
      p5s_q   <= p4s_q;
      v2_q    <= x6_q + x5_q + (LongW'(trim_i.p4) << 35);
      pv1_q   <= e_d;
      fine5_q <= fine4_q;
      temp5_q <= temp4_q;
      p6s_q   <= p5s_q;
      num_q   <= num_d;
      den_q   <= den_d;
      fine6_q <= fine5_q;
      temp6_q <= temp5_q;
    end
  end

  // fine_q is stage-3 output; stage tags realign below
  assign valid_o   = vld2_q[2];
  assign job_o.num = num_q;
  assign job_o.den = den_q;
  assign job_o.temp = temp6_q;
  assign job_o.fine = fine6_q;
  assign job_o.zero = (den_q == '0);
endmodule
`default_nettype wire

/* rtl/ptc_divider.sv */
`default_nettype none
// pipelined signed 64-bit divider, one quotient bit per stage
module ptc_divider
  import ptc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  div_job_t  job_i,
  output logic      valid_o,
  output div_res_t  res_o
);
  logic [DivSteps:0]  vld_q;
  logic [LongW-1:0]   rem_q [DivSteps+1];
  logic [LongW-1:0]   quo_q [DivSteps+1];
  logic [LongW-1:0]   den_q [DivSteps+1];
  logic               neg_q [DivSteps+1];
  logic [WordW-1:0]   temp_q [DivSteps+1];
  logic [WordW-1:0]   fine_q [DivSteps+1];
  logic               zero_q [DivSteps+1];

  logic na, nb;
  assign na = job_i.num[LongW-1];
  assign nb = job_i.den[LongW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[DivSteps-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      quo_q[0]  <= na ? (64'd0 - job_i.num) : job_i.num;
      den_q[0]  <= nb ? (64'd0 - job_i.den) : job_i.den;
      neg_q[0]  <= na ^ nb;
      temp_q[0] <= job_i.temp;
      fine_q[0] <= job_i.fine;
      zero_q[0] <= job_i.zero;
    end
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic [LongW:0] sh, df;
    assign sh = {rem_q[s], quo_q[s][LongW-1]};
    assign df = sh - {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= df[LongW] ? sh[LongW-1:0] : df[LongW-1:0];
        quo_q[s+1]  <= {quo_q[s][LongW-2:0], ~df[LongW]};
        den_q[s+1]  <= den_q[s];
        neg_q[s+1]  <= neg_q[s];
        temp_q[s+1] <= temp_q[s];
        fine_q[s+1] <= fine_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  assign valid_o    = vld_q[DivSteps];
  assign res_o.quo  = neg_q[DivSteps] ? (64'd0 - quo_q[DivSteps]) : quo_q[DivSteps];
  assign res_o.temp = temp_q[DivSteps];
  assign res_o.fine = fine_q[DivSteps];
  assign res_o.zero = zero_q[DivSteps];
endmodule
`default_nettype wire

/* rtl/ptc_back.sv */
`default_nettype none
// pressure correction after the quotient, 4 stages
module ptc_back
  import ptc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  div_res_t   res_i,
  input  trim_t      trim_i,
  output logic       valid_o,
  output logic [WordW-1:0] temp_o,
  output logic [WordW-1:0] press_o,
  output logic       inv_o,
  output logic [WordW-1:0] fine_o
);
  logic [3:0] vld_q;
  logic [LongW-1:0] p_q, ps_q, sq_q, p8_q, p_b, b8_q, ll_q;
  logic [LongW-1:0] a9_q, b8c_q, pc_q, press_q;
  logic [WordW-1:0] cr_q;
  logic [WordW-1:0] t_q [4];
  logic [WordW-1:0] f_q [4];
  logic             z_q [4];
  logic [LongW-1:0] ps_d;

  assign ps_d = LongW'($signed(res_i.quo) >>> 13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q  <= res_i.quo;
      sq_q <= LongW'(trim_i.p9) * ps_d;
      ps_q <= ps_d;
      p8_q <= LongW'($signed(LongW'(trim_i.p8) * res_i.quo) >>> 19);
      t_q[0] <= res_i.temp; f_q[0] <= res_i.fine; z_q[0] <= res_i.zero;
      // low 64 bits of sq * ps from 32x32 partial products
      ll_q <= LongW'(sq_q[WordW-1:0]) * LongW'(ps_q[WordW-1:0]);
      cr_q <= sq_q[LongW-1:WordW] * ps_q[WordW-1:0] +
              sq_q[WordW-1:0] * ps_q[LongW-1:WordW];
      b8_q <= p8_q;
      p_b  <= p_q;
      t_q[1] <= t_q[0]; f_q[1] <= f_q[0]; z_q[1] <= z_q[0];
      a9_q  <= LongW'($signed(ll_q + {cr_q, 32'b0}) >>> 25);
      b8c_q <= b8_q;
      pc_q  <= p_b;
      t_q[2] <= t_q[1]; f_q[2] <= f_q[1]; z_q[2] <= z_q[1];
      press_q <= LongW'($signed(pc_q + a9_q + b8c_q) >>> 8) +
                 (LongW'(trim_i.p7) << 4);
      t_q[3] <= t_q[2]; f_q[3] <= f_q[2]; z_q[3] <= z_q[2];
    end
  end

  assign valid_o = vld_q[3];
  assign temp_o  = t_q[3];
  assign fine_o  = f_q[3];
  assign inv_o   = z_q[3];
  assign press_o = z_q[3] ? '0 : press_q[WordW-1:0];
endmodule
`default_nettype wire

/* rtl/pressure_temperature_compensation_unit.sv */
// channel | dir | payload
// cfg     | in  | index[2:0], data[31:0]
// in      | in  | raw_temperature[19:0], raw_pressure[19:0]
// out     | out | temperature_centi, pressure_q24_8, pressure_invalid, fine_temperature
// One request per cycle unless out stalls; each passes the front, divider and back.
// The divider sets the latency; throughput is one per cycle unless out stalls.
// Reset clears valid bits and trims; the pipeline freezes while out is stalled.
`default_nettype none
`include "pressure_temperature_compensation_unit_macros.svh"
module pressure_temperature_compensation_unit
  import ptc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  ptc_cfg_if.sink    cfg,
  ptc_stream_if.sink in_s,
  ptc_stream_if.source out_s
);
  trim_t trim_q;
  logic  en, fv, dv, bv;
  div_job_t job;
  div_res_t res;
  logic [WordW-1:0] temp, press, fine;
  logic inv;

  assign en = !out_s.valid || out_s.ready;
  assign in_s.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q <= '0;
    end else if (cfg.valid) begin
      unique case (reg_idx_e'(cfg.index))
        RegT1:   trim_q.t1 <= cfg.data[15:0];
        RegT2:   trim_q.t2 <= cfg.data[15:0];
        RegT3:   trim_q.t3 <= cfg.data[15:0];
        RegP1:   trim_q.p1 <= cfg.data[15:0];
        RegP2P3: {trim_q.p3, trim_q.p2} <= cfg.data;
        RegP4P5: {trim_q.p5, trim_q.p4} <= cfg.data;
        RegP6P7: {trim_q.p7, trim_q.p6} <= cfg.data;
        RegP8P9: {trim_q.p9, trim_q.p8} <= cfg.data;
        default: ;
      endcase
    end
  end

  ptc_front u_front (.clk_i, .rst_ni, .en_i(en), .valid_i(in_s.valid && en),
    .adc_t_i(in_s.data[RawW-1:0]), .adc_p_i(in_s.data[2*RawW-1:RawW]),
    .trim_i(trim_q), .valid_o(fv), .job_o(job));
  ptc_divider u_div (.clk_i, .rst_ni, .en_i(en), .valid_i(fv), .job_i(job),
    .valid_o(dv), .res_o(res));
  ptc_back u_back (.clk_i, .rst_ni, .en_i(en), .valid_i(dv), .res_i(res),
    .trim_i(trim_q), .valid_o(bv), .temp_o(temp), .press_o(press),
    .inv_o(inv), .fine_o(fine));

  assign out_s.valid = bv;
  assign out_s.data  = {fine, inv, press, temp};

  `PTC_ASSERT_IMPL(a_stall_hold, clk_i, rst_ni, out_s.valid && !out_s.ready |=> out_s.valid)
  `PTC_ASSERT_IMPL(a_inv_zero, clk_i, rst_ni, out_s.valid && inv |-> press == '0)
  `PTC_ASSERT_RESET(a_rst_quiet, clk_i, rst_ni, out_s.valid)
endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import ptc_pkg::*;

  typedef struct {
    bit signed [31:0] temp;
    bit [31:0]        press;
    bit               inv;
    bit signed [31:0] fine;
  } comp_result_t;

  class comp_scoreboard;
    comp_result_t pending[$];
    int errors;

    function void note_request(comp_result_t r);
      pending.push_back(r);
    endfunction

    function void check_result(comp_result_t got);
      comp_result_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: temp %0d press %0h", got.temp, got.press);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.temp !== want.temp) begin
        $error("temperature_centi exp %0d got %0d", want.temp, got.temp);
        errors++;
      end
      if (got.press !== want.press) begin
        $error("pressure_q24_8 exp %0h got %0h", want.press, got.press);
        errors++;
      end
      if (got.inv !== want.inv) begin
        $error("pressure_invalid exp %0b got %0b", want.inv, got.inv);
        errors++;
      end
      if (got.fine !== want.fine) begin
        $error("fine_temperature exp %0d got %0d", want.fine, got.fine);
        errors++;
      end
    endfunction
  endclass

  localparam int OutW = 3 * WordW + 1;
  localparam int Latency = 76;
  localparam int WatchLimit = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  always #5 clk_i = ~clk_i;

  ptc_cfg_if cfg_if();
  ptc_stream_if #(.DataW(2 * RawW)) in_if();
  ptc_stream_if #(.DataW(OutW)) out_if();

  pressure_temperature_compensation_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg(cfg_if.sink), .in_s(in_if.sink), .out_s(out_if.source)
  );

  comp_scoreboard sb = new();
  bit [31:0] trim_regs[8];
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cnt;
  int quiet_cycles;

  function automatic comp_result_t compensate(bit [19:0] adc_t, bit [19:0] adc_p);
    comp_result_t r;
    bit [31:0] t1, t2, t3, dd;
    bit signed [31:0] a, d2, tv1, tv2, f, t5;
    bit signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
    t1 = {16'b0, trim_regs[RegT1][15:0]};
    t2 = {{16{trim_regs[RegT2][15]}}, trim_regs[RegT2][15:0]};
    t3 = {{16{trim_regs[RegT3][15]}}, trim_regs[RegT3][15:0]};
    p1 = {48'b0, trim_regs[RegP1][15:0]};
    p2 = {{48{trim_regs[RegP2P3][15]}}, trim_regs[RegP2P3][15:0]};
    p3 = {{48{trim_regs[RegP2P3][31]}}, trim_regs[RegP2P3][31:16]};
    p4 = {{48{trim_regs[RegP4P5][15]}}, trim_regs[RegP4P5][15:0]};
    p5 = {{48{trim_regs[RegP4P5][31]}}, trim_regs[RegP4P5][31:16]};
    p6 = {{48{trim_regs[RegP6P7][15]}}, trim_regs[RegP6P7][15:0]};
    p7 = {{48{trim_regs[RegP6P7][31]}}, trim_regs[RegP6P7][31:16]};
    p8 = {{48{trim_regs[RegP8P9][15]}}, trim_regs[RegP8P9][15:0]};
    p9 = {{48{trim_regs[RegP8P9][31]}}, trim_regs[RegP8P9][31:16]};
    a = (({12'b0, adc_t} >> 3) - (t1 << 1)) * t2;
    tv1 = a >>> 11;
    dd = ({12'b0, adc_t} >> 4) - t1;
    d2 = dd * dd;
    d2 = d2 >>> 12;
    a = d2 * t3;
    tv2 = a >>> 14;
    f = tv1 + tv2;
    t5 = f * 32'sd5 + 32'sd128;
    r.temp = t5 >>> 8;
    r.fine = f;
    v1 = {{32{f[31]}}, f} - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    p = v1 * v1 * p3;
    v1 = (p >>> 8) + ((v1 * p2) <<< 12);
    p = ((64'sd1 <<< 47) + v1) * p1;
    v1 = p >>> 33;
    r.inv = (v1 == 0);
    r.press = '0;
    if (!r.inv) begin
      p = 64'sd1048576 - {44'b0, adc_p};
      p = ((p <<< 31) - v2) * 64'sd3125;
      if (v1 == -64'sd1) p = -p;
      else p = p / v1;
      v1 = p9 * (p >>> 13) * (p >>> 13);
      v1 = v1 >>> 25;
      v2 = p8 * p;
      v2 = v2 >>> 19;
      p = p + v1 + v2;
      p = (p >>> 8) + (p7 <<< 4);
      r.press = p[31:0];
    end
    return r;
  endfunction

  task automatic write_trims(bit [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= reg_idx_e'(i);
      cfg_if.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      trim_regs[i] = (i < 4) ? (vals[i] & 32'hFFFF) : vals[i];
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_sample(bit [19:0] adc_t, bit [19:0] adc_p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {adc_p, adc_t};
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(compensate(adc_t, adc_p));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 6) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      comp_result_t got;
      got.temp  = out_if.data[31:0];
      got.press = out_if.data[63:32];
      got.inv   = out_if.data[64];
      got.fine  = out_if.data[96:65];
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles > WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    bit [31:0] vals[8];
    bit [19:0] edge_vals[5];
    rst_ni <= 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cnt = 0;
    quiet_cycles = 0;
    foreach (trim_regs[i]) trim_regs[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset trims: divisor is zero, pressure flagged invalid
    edge_vals = '{20'h00000, 20'hFFFFF, 20'hAAAAA, 20'h55555, 20'h80000};
    foreach (edge_vals[i]) send_sample(edge_vals[i], edge_vals[4 - i]);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      tx_idle_pct = (ph < 4) ? 8 : (ph < 8) ? 82 : 0;
      rx_idle_pct = (ph < 4) ? 82 : (ph < 8) ? 8 : 0;
      case (ph)
        0: vals = '{27504, 26435, 16'hFC18, 36477, 32'h0BD0D6B3,
                    32'h008C0B27, 32'h3C8CFFF9, 32'h1770C6F8};
        1: vals = '{32'hFFFF, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'h7FFF7FFF,
                    32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF};
        2: vals = '{0, 32'h8000, 32'h8000, 1, 32'h80008000,
                    32'h80008000, 32'h80008000, 32'h80008000};
        3: vals = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        4: vals = '{27504, 26435, 16'hFC18, 0, 32'h0BD0D6B3,
                    32'h008C0B27, 32'h3C8CFFF9, 32'h1770C6F8};
        default: foreach (vals[i]) vals[i] = $urandom();
      endcase
      write_trims(vals);
      if (ph == 8) hold_cnt = 400;
      if (ph == 0) begin
        foreach (edge_vals[i])
          foreach (edge_vals[j]) send_sample(edge_vals[i], edge_vals[j]);
      end
      for (int n = 0; n < 125; n++) begin
        if (n % 2 == 0) send_sample($urandom(), $urandom());
        else send_sample($urandom_range(600000, 400000), $urandom_range(500000, 200000));
      end
      drain();
    end

    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
